/* sv/stl_pkg.sv */
package stl_pkg;

	// Internal counter widths
	localparam int POS_W  = 32;
	localparam int LINE_W = 24;
	localparam int COL_W  = 16;

	// Result field widths
	localparam int OFFSET_W   = 32;
	localparam int LENGTH_W   = 32;
	localparam int LINE_OUT_W = 24;
	localparam int COL_OUT_W  = 16;

	// Keyword matching holds the first few bytes of an identifier
	localparam int PREFIX_BYTES = 5;
	localparam int PREFIX_W     = 8 * PREFIX_BYTES;

	localparam logic [PREFIX_W-1:0] KW_FN_TEXT    = 40'h00_00_00_6E_66;
	localparam logic [PREFIX_W-1:0] KW_LET_TEXT   = 40'h00_00_74_65_6C;
	localparam logic [PREFIX_W-1:0] KW_PRINT_TEXT = 40'h74_6E_69_72_70;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;

	// Result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_IDENT   = 3'd0,
		KIND_KEYWORD = 3'd1,
		KIND_NUMBER  = 3'd2,
		KIND_STRING  = 3'd3,
		KIND_SYMBOL  = 3'd4,
		KIND_END     = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		KW_NONE  = 2'd0,
		KW_FN    = 2'd1,
		KW_LET   = 2'd2,
		KW_PRINT = 2'd3
	} kw_t;

	typedef struct packed {
		kind_t                 kind;
		logic [OFFSET_W-1:0]   start;
		logic [LENGTH_W-1:0]   length;
		logic [LINE_OUT_W-1:0] line;
		logic [COL_OUT_W-1:0]  col;
		kw_t                   kw;
		logic [7:0]            sym;
		logic                  last;
	} result_t;

	// Up to two results from one item: a pending token, then a closing one
	typedef struct packed {
		logic    a_valid;
		result_t a;
		logic    b_valid;
		result_t b;
	} scan_out_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
	endfunction

	function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] line,
			input logic [7:0] c);
		if ((c == CH_NEWLINE) && (line != '1))
			return line + LINE_W'(1);
		return line;
	endfunction

	function automatic logic [COL_W-1:0] next_col(input logic [COL_W-1:0] col,
			input logic [7:0] c);
		if (c == CH_NEWLINE)
			return COL_W'(1);
		if (col != '1)
			return col + COL_W'(1);
		return col;
	endfunction

endpackage

/* sv/source_text_lexer.sv */
// Streaming lexer: source text in, one byte per transaction, tokens out.
// Input channel (src_valid / src_stall): op = 0 carries a source byte in
// character, op = 1 marks the end of the text. Output channel
// (tok_valid / tok_stall): one token per transaction, with kind, start
// offset, value length, line and column, keyword code and symbol byte;
// last_of_run flags the final token caused by one input transaction.
// A taken byte lands in the input register, is scanned and written to the
// result queue, and its first token can then be taken at the queue head.
// Throughput: one byte per cycle while the queue has room, set by the
// single-pass scan between the input register and the four-entry result
// queue; a byte that ends a token and also forms a symbol, and the end
// marker after a pending token, give two tokens, drained at one per cycle.
// Reset clears the scan mode, sets position to 0, line and column to 1 and
// empties the queue. While the receiver stalls, the head token holds; once
// the queue lacks room for two tokens the scan holds and src_stall rises.
// After the end marker all counters return to their reset values.
module source_text_lexer
	import stl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic        op,
	input  logic [7:0]  character,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [2:0]  token_kind,
	output logic [31:0] start_offset,
	output logic [31:0] value_length,
	output logic [23:0] line_number,
	output logic [15:0] column_number,
	output logic [1:0]  keyword_id,
	output logic [7:0]  symbol_byte,
	output logic        last_of_run
);

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] char_s1;
	logic       accept;
	logic       fire;
	logic       room;
	scan_out_t  scan;
	result_t    head;

	// Scan the held byte only when the queue can take two tokens
	assign fire      = valid_s1 && room;
	assign src_stall = valid_s1 && !fire;
	assign accept    = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset; load on every accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			char_s1 <= character;
		end
	end

	stl_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.op        (op_s1),
		.character (char_s1),
		.scan      (scan)
	);

	stl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (scan),
		.pop        (tok_valid && !tok_stall),
		.room       (room),
		.head_valid (tok_valid),
		.head       (head)
	);

	assign token_kind    = head.kind;
	assign start_offset  = head.start;
	assign value_length  = head.length;
	assign line_number   = head.line;
	assign column_number = head.col;
	assign keyword_id    = head.kw;
	assign symbol_byte   = head.sym;
	assign last_of_run   = head.last;

	// The end token always closes its run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && (token_kind == KIND_END)) |-> last_of_run)
		else $error("end token without last_of_run");

	// Only symbol tokens carry a byte
	a_sym_only: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && (token_kind != KIND_SYMBOL)) |-> (symbol_byte == 8'd0))
		else $error("symbol byte on a non-symbol token");

	// Keyword code present exactly on keyword tokens
	a_kw_match: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((token_kind == KIND_KEYWORD) == (keyword_id != KW_NONE)))
		else $error("keyword code and token kind disagree");

	// Line counter starts at one and saturates, so it never reads zero
	a_line_nz: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (line_number != '0))
		else $error("line number zero");

endmodule

/* sv/stl_scan.sv */
module stl_scan
	import stl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic       op,
	input  logic [7:0] character,
	output scan_out_t  scan
);

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_IDENT  = 3'd1,
		MODE_INT    = 3'd2,
		MODE_FRAC   = 3'd3,
		MODE_STRING = 3'd4
	} mode_t;

	mode_t               mode_q, mode_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [LINE_W-1:0]   line_q, line_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [POS_W-1:0]    tstart_q, tstart_d;
	logic [PREFIX_W-1:0] prefix_q, prefix_d;

	always_comb begin
		logic [POS_W-1:0]  len;
		logic [POS_W-1:0]  pos_inc;
		logic [LINE_W-1:0] line_inc;
		logic [COL_W-1:0]  col_inc;
		logic              go_idle;
		logic              a_v;
		logic              b_v;
		kw_t               kw;
		result_t           a;
		result_t           b;

		mode_d   = mode_q;
		pos_d    = pos_q;
		line_d   = line_q;
		col_d    = col_q;
		tstart_d = tstart_q;
		prefix_d = prefix_q;

		len      = pos_q - tstart_q;
		pos_inc  = pos_q + POS_W'(1);
		line_inc = next_line(line_q, character);
		col_inc  = next_col(col_q, character);
		go_idle  = 1'b0;
		a_v      = 1'b0;
		b_v      = 1'b0;

		// Pending token, stamped with the position before the current byte
		kw = KW_NONE;
		if ((len == POS_W'(2)) && (prefix_q == KW_FN_TEXT))
			kw = KW_FN;
		else if ((len == POS_W'(3)) && (prefix_q == KW_LET_TEXT))
			kw = KW_LET;
		else if ((len == POS_W'(5)) && (prefix_q == KW_PRINT_TEXT))
			kw = KW_PRINT;

		a.start  = OFFSET_W'(tstart_q);
		a.length = LENGTH_W'(len);
		a.line   = LINE_OUT_W'(line_q);
		a.col    = COL_OUT_W'(col_q);
		a.sym    = 8'd0;
		a.last   = 1'b0;
		case (mode_q)
			MODE_IDENT: begin
				a.kind = (kw != KW_NONE) ? KIND_KEYWORD : KIND_IDENT;
				a.kw   = kw;
			end
			MODE_STRING: begin
				a.kind = KIND_STRING;
				a.kw   = KW_NONE;
			end
			default: begin
				a.kind = KIND_NUMBER;
				a.kw   = KW_NONE;
			end
		endcase

		// Symbol by default; replaced by string close or end token
		b.kind   = KIND_SYMBOL;
		b.start  = OFFSET_W'(pos_q);
		b.length = LENGTH_W'(1);
		b.line   = LINE_OUT_W'(line_inc);
		b.col    = COL_OUT_W'(col_inc);
		b.kw     = KW_NONE;
		b.sym    = character;
		b.last   = 1'b1;

		if (op) begin
			a_v      = (mode_q != MODE_IDLE);
			b_v      = 1'b1;
			b.kind   = KIND_END;
			b.length = '0;
			b.line   = LINE_OUT_W'(line_q);
			b.col    = COL_OUT_W'(col_q);
			b.sym    = 8'd0;
			mode_d   = MODE_IDLE;
			pos_d    = '0;
			line_d   = LINE_W'(1);
			col_d    = COL_W'(1);
			tstart_d = '0;
			prefix_d = '0;
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					if (is_word(character)) begin
						for (int i = 0; i < PREFIX_BYTES; i++) begin
							if (len == POS_W'(i))
								prefix_d[8*i +: 8] = prefix_q[8*i +: 8] | character;
						end
						pos_d  = pos_inc;
						line_d = line_inc;
						col_d  = col_inc;
					end else begin
						a_v     = 1'b1;
						go_idle = 1'b1;
					end
				end
				MODE_INT: begin
					if (is_digit(character) || (character == CH_DOT)) begin
						pos_d  = pos_inc;
						line_d = line_inc;
						col_d  = col_inc;
						if (character == CH_DOT)
							mode_d = MODE_FRAC;
					end else begin
						a_v     = 1'b1;
						go_idle = 1'b1;
					end
				end
				MODE_FRAC: begin
					if (is_digit(character)) begin
						pos_d  = pos_inc;
						line_d = line_inc;
						col_d  = col_inc;
					end else begin
						a_v     = 1'b1;
						go_idle = 1'b1;
					end
				end
				MODE_STRING: begin
					pos_d  = pos_inc;
					line_d = line_inc;
					col_d  = col_inc;
					if (character == CH_QUOTE) begin
						b_v      = 1'b1;
						b.kind   = KIND_STRING;
						b.start  = OFFSET_W'(tstart_q);
						b.length = LENGTH_W'(len);
						b.sym    = 8'd0;
						mode_d   = MODE_IDLE;
					end
				end
				default: go_idle = 1'b1;
			endcase

			// Handle the byte as a fresh start; every class consumes it
			if (go_idle) begin
				mode_d = MODE_IDLE;
				pos_d  = pos_inc;
				line_d = line_inc;
				col_d  = col_inc;
				if (is_alpha(character) || (character == CH_UNDERSCORE)) begin
					mode_d   = MODE_IDENT;
					tstart_d = pos_q;
					prefix_d = PREFIX_W'(character);
				end else if (is_digit(character)) begin
					mode_d   = MODE_INT;
					tstart_d = pos_q;
				end else if (character == CH_QUOTE) begin
					mode_d   = MODE_STRING;
					tstart_d = pos_inc;
				end else if (!is_space(character)) begin
					b_v = 1'b1;
				end
			end
		end

		a.last       = !b_v;
		scan.a       = a;
		scan.b       = b;
		scan.a_valid = fire && a_v;
		scan.b_valid = fire && b_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			line_q   <= LINE_W'(1);
			col_q    <= COL_W'(1);
			tstart_q <= '0;
			prefix_q <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			col_q    <= col_d;
			tstart_q <= tstart_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

/* sv/stl_queue.sv */
module stl_queue
	import stl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  scan_out_t push,
	input  logic      pop,
	output logic      room,
	output logic      head_valid,
	output result_t   head
);

	result_t           mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W-1:0] n_push;
	result_t           w0;

	assign n_push     = QCNT_W'(push.a_valid) + QCNT_W'(push.b_valid);
	assign w0         = push.a_valid ? push.a : push.b;
	assign room       = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (n_push != '0)
			mem[wr_ptr_q] <= w0;
		if (push.a_valid && push.b_valid)
			mem[wr_ptr_q + QPTR_W'(1)] <= push.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + n_push - QCNT_W'(pop);
		end
	end

endmodule
